// ===== rtl/core/ibhq_pkg.sv =====
// ----------------------------------------------------------------------------
// ibhq_pkg: shared types and constants for the indexed binary heap queue
// Fixed sizes, command codes and the sequencer-to-memory request struct.
// ----------------------------------------------------------------------------
package ibhq_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned IdW      = 9;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned SlotW    = 9;
  localparam int unsigned CmdW     = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_INVERT = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  // One write to the heap slot store and one to the position map.
  typedef struct packed {
    logic             heap_we;
    logic [SlotW-1:0] heap_addr;
    logic [IdW-1:0]   heap_id;
    logic [KeyW-1:0]  heap_key;
    logic             pos_we;
    logic [IdW-1:0]   pos_addr;
    logic [SlotW-1:0] pos_data;
  } mem_wr_t;

  // True when key a has strictly higher priority than key b.
  function automatic logic better(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b,
                                  input logic max_first);
    logic lt;
    lt = $signed(a) < $signed(b);
    return max_first ? ($signed(a) > $signed(b)) : lt;
  endfunction

endpackage

// ===== rtl/core/indexed_binary_heap_queue_top.sv =====
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue_top: indexed binary heap priority queue
// Stream in commands, stream out one status result per command.
// ----------------------------------------------------------------------------
// One command at a time: insert, update and remove walk the slot memory, which
// has one read port, going up for a sift-up and down for a sift-down; query
// only reads the result. Invert rebuilds bottom-up over fill_count/2
// sift-downs. The result is held in an output register; the next command is
// accepted only once that result has been taken or is taken in the same cycle.
module indexed_binary_heap_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cmd[1:0], elem_id[10:2], key_value[42:11], zero pad to 48
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: entry_count[8:0], is_empty[9], top_id[18:10], top_key[50:19],
  // id_present[51], id_key[83:52], zero pad to 88
  output logic [87:0] m_axis_tdata
);
  import ibhq_pkg::*;

  mem_wr_t          wr;
  logic [SlotW-1:0] heap_raddr, pos_rdata, cnt;
  logic [IdW-1:0]   heap_rid, pos_raddr, top_id;
  logic [KeyW-1:0]  heap_rkey, top_key, id_key;
  logic             busy, done, present, start, cap_q;
  logic             out_valid_q;
  logic [87:0]      out_q;

  assign start = s_axis_tvalid && s_axis_tready;
  // accept only when the sequencer is idle and no result is pending capture
  assign s_axis_tready = !busy && !cap_q && !(out_valid_q && !m_axis_tready);

  ibhq_store u_store (
    .clk_i, .rst_ni, .wr_i(wr), .heap_raddr_i(heap_raddr), .heap_rid_o(heap_rid),
    .heap_rkey_o(heap_rkey), .pos_raddr_i(pos_raddr), .pos_rdata_o(pos_rdata)
  );

  ibhq_seq u_seq (
    .clk_i, .rst_ni, .start_i(start), .cmd_i(s_axis_tdata[1:0]),
    .id_i(s_axis_tdata[10:2]), .key_i(s_axis_tdata[42:11]), .busy_o(busy),
    .done_o(done), .wr_o(wr), .heap_raddr_o(heap_raddr), .heap_rid_i(heap_rid),
    .heap_rkey_i(heap_rkey), .pos_raddr_o(pos_raddr), .pos_rdata_i(pos_rdata),
    .count_o(cnt), .top_id_o(top_id), .top_key_o(top_key), .present_o(present),
    .id_key_o(id_key)
  );

  // capture in the cycle after done, when the id key read has returned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q <= done;
      if (cap_q) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_q) begin
      out_q <= {4'd0, id_key, present, top_key, top_id, (cnt == '0), cnt};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
endmodule

// ===== rtl/core/ibhq_store.sv =====
// ----------------------------------------------------------------------------
// ibhq_store: heap slot memory and position map memory
// Synchronous-read memories; position map entries carry valid bits.
// ----------------------------------------------------------------------------
module ibhq_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ibhq_pkg::mem_wr_t         wr_i,
  input  logic [ibhq_pkg::SlotW-1:0] heap_raddr_i,
  output logic [ibhq_pkg::IdW-1:0]  heap_rid_o,
  output logic [ibhq_pkg::KeyW-1:0] heap_rkey_o,
  input  logic [ibhq_pkg::IdW-1:0]  pos_raddr_i,
  output logic [ibhq_pkg::SlotW-1:0] pos_rdata_o
);
  import ibhq_pkg::*;

  logic [IdW-1:0]   ids_mem  [Capacity+1];
  logic [KeyW-1:0]  keys_mem [Capacity+1];
  logic [SlotW-1:0] pos_mem  [Capacity+1];
  logic [Capacity:0] pos_valid_q;
  logic             pos_hit_q;
  logic [SlotW-1:0] pos_raw_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.heap_we) begin
      ids_mem[wr_i.heap_addr]  <= wr_i.heap_id;
      keys_mem[wr_i.heap_addr] <= wr_i.heap_key;
    end
    heap_rid_o  <= ids_mem[heap_raddr_i];
    heap_rkey_o <= keys_mem[heap_raddr_i];
    if (wr_i.pos_we) begin
      pos_mem[wr_i.pos_addr] <= wr_i.pos_data;
    end
    pos_raw_q <= pos_mem[pos_raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_valid_q <= '0;
      pos_hit_q   <= 1'b0;
    end else begin
      if (wr_i.pos_we) begin
        pos_valid_q[wr_i.pos_addr] <= 1'b1;
      end
      pos_hit_q <= pos_valid_q[pos_raddr_i];
    end
  end

  assign pos_rdata_o = pos_hit_q ? pos_raw_q : '0;
endmodule

// ===== rtl/core/ibhq_seq.sv =====
// ----------------------------------------------------------------------------
// ibhq_seq: command sequencer with one shared key comparator
// Walks sift-up, sift-down and bottom-up rebuild one memory access per step.
// ----------------------------------------------------------------------------
module ibhq_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ibhq_pkg::CmdW-1:0]  cmd_i,
  input  logic [ibhq_pkg::IdW-1:0]   id_i,
  input  logic [ibhq_pkg::KeyW-1:0]  key_i,
  output logic                       busy_o,
  output logic                       done_o,
  output ibhq_pkg::mem_wr_t          wr_o,
  output logic [ibhq_pkg::SlotW-1:0] heap_raddr_o,
  input  logic [ibhq_pkg::IdW-1:0]   heap_rid_i,
  input  logic [ibhq_pkg::KeyW-1:0]  heap_rkey_i,
  output logic [ibhq_pkg::IdW-1:0]   pos_raddr_o,
  input  logic [ibhq_pkg::SlotW-1:0] pos_rdata_i,
  output logic [ibhq_pkg::SlotW-1:0] count_o,
  output logic [ibhq_pkg::IdW-1:0]   top_id_o,
  output logic [ibhq_pkg::KeyW-1:0]  top_key_o,
  output logic                       present_o,
  output logic [ibhq_pkg::KeyW-1:0]  id_key_o
);
  import ibhq_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001, S_POS   = 18'h00002, S_POSW  = 18'h00004,
    S_OLDW  = 18'h00008, S_RLAST = 18'h00010, S_RLW   = 18'h00020,
    S_UPRD  = 18'h00040, S_UPW   = 18'h00080, S_DNL   = 18'h00100,
    S_DNR   = 18'h00200, S_DNLW  = 18'h00400, S_DNRW  = 18'h00800,
    S_INVRD = 18'h01000, S_INVW  = 18'h02000, S_FINR  = 18'h04000,
    S_FINW  = 18'h08000, S_DONE  = 18'h10000, S_QPW   = 18'h20000
  } state_e;

  state_e           state_q, state_d;
  logic [SlotW-1:0] cnt_q, cnt_d;
  logic             maxf_q, maxf_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW-1:0] inv_q, inv_d;
  logic [IdW-1:0]   cid_q, cid_d;
  logic [KeyW-1:0]  ckey_q, ckey_d;
  logic [IdW-1:0]   lid_q, lid_d;
  logic [KeyW-1:0]  lkey_q, lkey_d;
  logic             inv_mode_q, inv_mode_d;
  logic [CmdW-1:0]  cmd_q;
  logic [IdW-1:0]   id_q;
  logic [KeyW-1:0]  key_q;
  logic [IdW-1:0]   topid_q, topid_d;
  logic [KeyW-1:0]  topkey_q, topkey_d;
  logic             pres_q, pres_d;
  logic [SlotW:0]   child2;
  logic             in_range;
  logic             cmp_out;
  logic [KeyW-1:0]  cmp_a, cmp_b;

  assign in_range = (id_q != '0) && (32'(id_q) <= Capacity);
  assign child2   = {slot_q, 1'b0};
  assign cmp_out  = better(cmp_a, cmp_b, maxf_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      maxf_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      maxf_q  <= maxf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d; inv_q <= inv_d; cid_q <= cid_d; ckey_q <= ckey_d;
    lid_q <= lid_d; lkey_q <= lkey_d; inv_mode_q <= inv_mode_d;
    topid_q <= topid_d; topkey_q <= topkey_d; pres_q <= pres_d;
    if (start_i) begin
      cmd_q <= cmd_i; id_q <= id_i; key_q <= key_i;
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; maxf_d = maxf_q; slot_d = slot_q;
    inv_d = inv_q; cid_d = cid_q; ckey_d = ckey_q; lid_d = lid_q; lkey_d = lkey_q;
    inv_mode_d = inv_mode_q; topid_d = topid_q; topkey_d = topkey_q;
    pres_d = pres_q;
    wr_o = '0; heap_raddr_o = slot_q; pos_raddr_o = id_q;
    cmp_a = ckey_q; cmp_b = heap_rkey_i;
    done_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_POS;
      end
      S_POS: begin
        inv_mode_d = 1'b0;
        heap_raddr_o = '0;
        case (cmd_e'(cmd_q))
          CMD_INSERT: state_d = in_range ? S_POSW : S_FINR;
          CMD_REMOVE: begin
            if (cnt_q == '0) state_d = S_FINR;
            else begin
              heap_raddr_o = SlotW'(1);
              state_d = S_RLAST;
            end
          end
          CMD_INVERT: begin
            maxf_d = !maxf_q;
            inv_d = cnt_q >> 1;
            inv_mode_d = 1'b1;
            state_d = (cnt_q >> 1) != '0 ? S_INVRD : S_FINR;
          end
          default: state_d = S_FINR;
        endcase
      end
      S_POSW: begin
        // pos read is out; fetch the current slot contents if present
        if (pos_rdata_i != '0) begin
          slot_d = pos_rdata_i;
          heap_raddr_o = pos_rdata_i;
          state_d = S_OLDW;
        end else begin
          cnt_d = cnt_q + 1'b1;
          slot_d = cnt_q + 1'b1;
          cid_d = id_q; ckey_d = key_q;
          state_d = S_UPRD;
        end
        cid_d = id_q; ckey_d = key_q;
      end
      S_OLDW: begin
        cmp_a = key_q; cmp_b = heap_rkey_i;
        state_d = cmp_out ? S_UPRD : S_DNL;
      end
      S_RLAST: begin
        // root id was read; unmap it and read the last slot
        wr_o.pos_we = 1'b1; wr_o.pos_addr = heap_rid_i; wr_o.pos_data = '0;
        heap_raddr_o = cnt_q;
        state_d = S_RLW;
      end
      S_RLW: begin
        cid_d = heap_rid_i; ckey_d = heap_rkey_i;
        cnt_d = cnt_q - 1'b1;
        slot_d = SlotW'(1);
        state_d = (cnt_q - 1'b1) != '0 ? S_DNL : S_FINR;
      end
      S_UPRD: begin
        if (slot_q > SlotW'(1)) begin
          heap_raddr_o = slot_q >> 1;
          state_d = S_UPW;
        end else state_d = S_FINW;
      end
      S_UPW: begin
        if (cmp_out) begin
          wr_o.heap_we = 1'b1; wr_o.heap_addr = slot_q;
          wr_o.heap_id = heap_rid_i; wr_o.heap_key = heap_rkey_i;
          wr_o.pos_we = 1'b1; wr_o.pos_addr = heap_rid_i; wr_o.pos_data = slot_q;
          slot_d = slot_q >> 1;
          state_d = S_UPRD;
        end else state_d = S_FINW;
      end
      S_DNL: begin
        if (child2 > {1'b0, cnt_q}) state_d = S_FINW;
        else begin
          heap_raddr_o = child2[SlotW-1:0];
          state_d = S_DNR;
        end
      end
      S_DNR: begin
        lid_d = heap_rid_i; lkey_d = heap_rkey_i;
        if (child2 + 1'b1 <= {1'b0, cnt_q}) begin
          heap_raddr_o = SlotW'(child2 + 1'b1);
          state_d = S_DNRW;
        end else state_d = S_DNLW;
      end
      S_DNLW: begin
        cmp_a = lkey_q; cmp_b = ckey_q;
        if (cmp_out) begin
          wr_o.heap_we = 1'b1; wr_o.heap_addr = slot_q;
          wr_o.heap_id = lid_q; wr_o.heap_key = lkey_q;
          wr_o.pos_we = 1'b1; wr_o.pos_addr = lid_q; wr_o.pos_data = slot_q;
          slot_d = child2[SlotW-1:0];
          state_d = S_DNL;
        end else state_d = S_FINW;
      end
      S_DNRW: begin
        cmp_a = heap_rkey_i; cmp_b = lkey_q;
        if (cmp_out) begin
          // right child wins the pick; stash it as the candidate
          lid_d = heap_rid_i; lkey_d = heap_rkey_i;
          slot_d = slot_q;
          state_d = S_QPW;
        end else state_d = S_DNLW;
      end
      S_QPW: begin
        cmp_a = lkey_q; cmp_b = ckey_q;
        if (cmp_out) begin
          wr_o.heap_we = 1'b1; wr_o.heap_addr = slot_q;
          wr_o.heap_id = lid_q; wr_o.heap_key = lkey_q;
          wr_o.pos_we = 1'b1; wr_o.pos_addr = lid_q; wr_o.pos_data = slot_q;
          slot_d = SlotW'(child2 + 1'b1);
          state_d = S_DNL;
        end else state_d = S_FINW;
      end
      S_INVRD: begin
        heap_raddr_o = inv_q;
        slot_d = inv_q;
        state_d = S_INVW;
      end
      S_INVW: begin
        cid_d = heap_rid_i; ckey_d = heap_rkey_i;
        state_d = S_DNL;
      end
      S_FINW: begin
        wr_o.heap_we = 1'b1; wr_o.heap_addr = slot_q;
        wr_o.heap_id = cid_q; wr_o.heap_key = ckey_q;
        wr_o.pos_we = 1'b1; wr_o.pos_addr = cid_q; wr_o.pos_data = slot_q;
        if (inv_mode_q && inv_q > SlotW'(1)) begin
          inv_d = inv_q - 1'b1;
          state_d = S_INVRD;
        end else state_d = S_FINR;
      end
      S_FINR: begin
        heap_raddr_o = SlotW'(1);
        pos_raddr_o = id_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        // root and position are out; fetch the id's key next
        topid_d = (cnt_q != '0) ? heap_rid_i : '0;
        topkey_d = (cnt_q != '0) ? heap_rkey_i : '0;
        pres_d = in_range && (pos_rdata_i != '0);
        heap_raddr_o = pos_rdata_i;
        slot_d = '0;
        state_d = S_IDLE;
        done_o = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // id key arrives in the cycle after done; output stage samples it then
  assign busy_o  = state_q != S_IDLE;
  assign count_o = cnt_q;
  assign top_id_o = topid_q;
  assign top_key_o = topkey_q;
  assign present_o = pres_q;
  assign id_key_o = pres_q ? heap_rkey_i : '0;
endmodule

// ===== rtl/core/ibhq_checker.sv =====
// ----------------------------------------------------------------------------
// ibhq_checker: port-level checks for the heap queue
// Watches handshake and result consistency on the top-level ports.
// ----------------------------------------------------------------------------
module ibhq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[9] == (m_axis_tdata[8:0] == 9'd0)))
    else $error("empty flag mismatch");
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[9]) |-> (m_axis_tdata[50:10] == '0))
    else $error("top not zero when empty");
  a_absent_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[51]) |-> (m_axis_tdata[83:52] == '0))
    else $error("absent id key not zero");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted two back to back");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");
endmodule

bind indexed_binary_heap_queue_top ibhq_checker u_ibhq_checker (.*);
